@@ src/isosurface_edge_interpolate_macros.svh @@
// Assertion macros shared by the isosurface edge interpolator checker.
// No dependencies; include by bare file name.
`ifndef ISOSURFACE_EDGE_INTERPOLATE_MACROS_SVH
`define ISOSURFACE_EDGE_INTERPOLATE_MACROS_SVH

// Property checked on every clock edge outside reset.
`define IEI_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define IEI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/ied_pkg.sv @@
// Shared types and constants for the isosurface edge interpolator.
// No dependencies.
package ied_pkg;

   localparam int DATA_W         = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int DIV_STEPS      = 32;
   localparam int AXES           = 3;

   // Per-item sideband that travels alongside the divider.
   typedef struct packed {
      logic [AXES-1:0][DATA_W-1:0] a;      // endpoint a
      logic [AXES-1:0][DATA_W-1:0] dmag;   // |b - a|
      logic [AXES-1:0]             dneg;   // b - a < 0
      logic                        neg;    // lambda negative
      logic                        degen;  // field values equal
      logic                        ovf;    // quotient >= 2^32
   } side_type;

endpackage

@@ src/ied_prep.sv @@
// Front end: differences, magnitudes and divider seed in two stages.
// Depends on ied_pkg.
module ied_prep #(
   parameter int FRAC_BITS = ied_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic signed [31:0]          iso,
   input  logic signed [31:0]          a_x, a_y, a_z, field_a,
   input  logic signed [31:0]          b_x, b_y, b_z, field_b,
   output logic                        out_valid,
   output ied_pkg::side_type           out_side,
   output logic [31:0]                 out_rem,
   output logic [31:0]                 out_nlow,
   output logic [31:0]                 out_den
);
   localparam int SHIFT_W = ied_pkg::DATA_W - FRAC_BITS;

   logic              v1_ff, v2_ff;
   logic signed [32:0] num_ff, den_ff;
   logic signed [32:0] d_ff [3];
   logic [31:0]        a_ff [3];

   logic [31:0]        nmag, dnmag;
   logic [31:0]        dm [3];
   logic [31:0]        rem_in;
   ied_pkg::side_type  side_in;
   ied_pkg::side_type  side_ff;
   logic [31:0]        rem_ff, nlow_ff, den_ff2;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff  <= 33'($signed(iso)) - 33'($signed(field_a));
         den_ff  <= 33'($signed(field_b)) - 33'($signed(field_a));
         d_ff[0] <= 33'($signed(b_x)) - 33'($signed(a_x));
         d_ff[1] <= 33'($signed(b_y)) - 33'($signed(a_y));
         d_ff[2] <= 33'($signed(b_z)) - 33'($signed(a_z));
         a_ff[0] <= a_x;
         a_ff[1] <= a_y;
         a_ff[2] <= a_z;
      end
   end

   always_comb begin
      nmag  = num_ff[32] ? 32'(-num_ff) : num_ff[31:0];
      dnmag = den_ff[32] ? 32'(-den_ff) : den_ff[31:0];
      for (int k = 0; k < 3; k++) begin
         dm[k]             = d_ff[k][32] ? 32'(-d_ff[k]) : d_ff[k][31:0];
         side_in.a[k]      = a_ff[k];
         side_in.dmag[k]   = dm[k];
         side_in.dneg[k]   = d_ff[k][32];
      end
      rem_in        = nmag >> SHIFT_W;
      side_in.neg   = num_ff[32] ^ den_ff[32];
      side_in.degen = (den_ff == '0);
      side_in.ovf   = (rem_in >= dnmag);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= side_in;
         rem_ff  <= rem_in;
         nlow_ff <= nmag << FRAC_BITS;
         den_ff2 <= dnmag;
      end
   end

   assign out_valid = v2_ff;
   assign out_side  = side_ff;
   assign out_rem   = rem_ff;
   assign out_nlow  = nlow_ff;
   assign out_den   = den_ff2;

endmodule

@@ src/ied_div_step.sv @@
// One restoring-division stage: produces one quotient bit.
// Depends on ied_pkg.
module ied_div_step (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  ied_pkg::side_type in_side,
   input  logic [31:0]       in_rem,
   input  logic [31:0]       in_nlow,
   input  logic [31:0]       in_den,
   input  logic [31:0]       in_quot,
   output logic              out_valid,
   output ied_pkg::side_type out_side,
   output logic [31:0]       out_rem,
   output logic [31:0]       out_nlow,
   output logic [31:0]       out_den,
   output logic [31:0]       out_quot
);
   logic              valid_ff;
   ied_pkg::side_type side_ff;
   logic [31:0]       rem_ff, nlow_ff, den_ff, quot_ff;
   logic [32:0]       trial;
   logic [32:0]       diff;
   logic              take;

   always_comb begin
      trial = {in_rem, in_nlow[31]};
      diff  = trial - {1'b0, in_den};
      take  = !diff[32];
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (en) valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= in_side;
         rem_ff  <= take ? diff[31:0] : trial[31:0];
         nlow_ff <= {in_nlow[30:0], 1'b0};
         den_ff  <= in_den;
         quot_ff <= {in_quot[30:0], take};
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_rem   = rem_ff;
   assign out_nlow  = nlow_ff;
   assign out_den   = den_ff;
   assign out_quot  = quot_ff;

endmodule

@@ src/ied_lerp.sv @@
// Back end: clip lambda, scale the edge vector, add endpoint a, saturate; degenerate edges give a.
// Depends on ied_pkg.
module ied_lerp #(
   parameter int FRAC_BITS = ied_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  ied_pkg::side_type in_side,
   input  logic [31:0]       in_quot,
   output logic              out_valid,
   output logic [2:0][31:0]  out_point,
   output logic              out_degen,
   output logic              out_sat
);
   localparam logic signed [65:0] MAX_V = 66'sd2147483647;
   localparam logic signed [65:0] MIN_V = -66'sd2147483648;

   logic              v1_ff, v2_ff, v3_ff;
   ied_pkg::side_type s1_ff, s2_ff;
   logic [31:0]       lm_in, lm_ff;
   logic              lsat_in, lsat1_ff, lsat2_ff;
   logic [63:0]       prod_ff [3];
   logic [2:0]        pneg_ff;

   logic [63:0]        m;
   logic signed [65:0] sv, vv;
   logic [2:0][31:0]   pt_in;
   logic               sat_in;
   logic [2:0][31:0]   pt_ff;
   logic               degen_ff, sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Clip lambda magnitude to the signed 32-bit range.
   always_comb begin
      lm_in   = in_quot;
      lsat_in = 1'b0;
      if (in_side.neg) begin
         if (in_side.ovf || in_quot > 32'h8000_0000) begin
            lm_in   = 32'h8000_0000;
            lsat_in = 1'b1;
         end
      end else begin
         if (in_side.ovf || in_quot[31]) begin
            lm_in   = 32'h7FFF_FFFF;
            lsat_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff    <= in_side;
         lm_ff    <= lm_in;
         lsat1_ff <= lsat_in;
         s2_ff    <= s1_ff;
         lsat2_ff <= lsat1_ff;
         for (int k = 0; k < 3; k++) begin
            prod_ff[k] <= 64'(s1_ff.dmag[k]) * 64'(lm_ff);
            pneg_ff[k] <= s1_ff.dneg[k] ^ s1_ff.neg;
         end
      end
   end

   always_comb begin
      sat_in = lsat2_ff;
      pt_in  = '0;
      m      = '0;
      sv     = '0;
      vv     = '0;
      for (int k = 0; k < 3; k++) begin
         m  = prod_ff[k] >> FRAC_BITS;
         sv = pneg_ff[k] ? -$signed({2'b00, m}) : $signed({2'b00, m});
         vv = 66'($signed(s2_ff.a[k])) + sv;
         if (vv > MAX_V) begin
            pt_in[k] = MAX_V[31:0];
            sat_in   = 1'b1;
         end else if (vv < MIN_V) begin
            pt_in[k] = MIN_V[31:0];
            sat_in   = 1'b1;
         end else begin
            pt_in[k] = vv[31:0];
         end
      end
      if (s2_ff.degen) begin
         pt_in  = s2_ff.a;
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pt_ff    <= pt_in;
         degen_ff <= s2_ff.degen;
         sat_ff   <= sat_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_point = pt_ff;
   assign out_degen = degen_ff;
   assign out_sat   = sat_ff;

endmodule

@@ src/isosurface_edge_interpolate.sv @@
// Pipeline: 2 prep, 32 divide and 3 lerp stages from req accept to rsp_valid.
// Throughput: one item per cycle unless the output is stalled; the 32-stage restoring divider dominates latency.
// The whole pipe advances together; it holds while rsp_valid waits on rsp_ready.
// Reset: synchronous, active high; clears valid bits and sets iso_value to 0.
// Depends on ied_pkg, ied_prep, ied_div_step, ied_lerp.
module isosurface_edge_interpolate #(
   parameter int FRAC_BITS = ied_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // configuration: iso_value
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic signed [31:0] csr_wdata,
   // edge items in
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_a_x,
   input  logic signed [31:0] req_a_y,
   input  logic signed [31:0] req_a_z,
   input  logic signed [31:0] req_field_a,
   input  logic signed [31:0] req_b_x,
   input  logic signed [31:0] req_b_y,
   input  logic signed [31:0] req_b_z,
   input  logic signed [31:0] req_field_b,
   // crossing points out
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_point_x,
   output logic signed [31:0] rsp_point_y,
   output logic signed [31:0] rsp_point_z,
   output logic               rsp_degenerate,
   output logic               rsp_saturated
);
   localparam int STEPS = ied_pkg::DIV_STEPS;

   logic signed [31:0] iso_ff;
   logic               advance;

   // Divider stage chain; index 0 is the prep output.
   logic              dv   [STEPS+1];
   ied_pkg::side_type ds   [STEPS+1];
   logic [31:0]       drem [STEPS+1];
   logic [31:0]       dnl  [STEPS+1];
   logic [31:0]       dden [STEPS+1];
   logic [31:0]       dq   [STEPS+1];

   logic [2:0][31:0]  point;

   // Configuration must only be written while idle; the block does not enforce this and always accepts it.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) iso_ff <= '0;
      else if (csr_valid) iso_ff <= csr_wdata;
   end

   // Advance every stage together unless the output item is stalled.
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   ied_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
      .clock    (clock),
      .reset    (reset),
      .en       (advance),
      .in_valid (req_valid),
      .iso      (iso_ff),
      .a_x      (req_a_x),
      .a_y      (req_a_y),
      .a_z      (req_a_z),
      .field_a  (req_field_a),
      .b_x      (req_b_x),
      .b_y      (req_b_y),
      .b_z      (req_b_z),
      .field_b  (req_field_b),
      .out_valid(dv[0]),
      .out_side (ds[0]),
      .out_rem  (drem[0]),
      .out_nlow (dnl[0]),
      .out_den  (dden[0])
   );
   assign dq[0] = '0;

   // One quotient bit per stage, most significant first.
   for (genvar k = 0; k < STEPS; k++) begin : g_div
      ied_div_step u_step (
         .clock    (clock),
         .reset    (reset),
         .en       (advance),
         .in_valid (dv[k]),
         .in_side  (ds[k]),
         .in_rem   (drem[k]),
         .in_nlow  (dnl[k]),
         .in_den   (dden[k]),
         .in_quot  (dq[k]),
         .out_valid(dv[k+1]),
         .out_side (ds[k+1]),
         .out_rem  (drem[k+1]),
         .out_nlow (dnl[k+1]),
         .out_den  (dden[k+1]),
         .out_quot (dq[k+1])
      );
   end

   ied_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp (
      .clock    (clock),
      .reset    (reset),
      .en       (advance),
      .in_valid (dv[STEPS]),
      .in_side  (ds[STEPS]),
      .in_quot  (dq[STEPS]),
      .out_valid(rsp_valid),
      .out_point(point),
      .out_degen(rsp_degenerate),
      .out_sat  (rsp_saturated)
   );

   assign rsp_point_x = point[0];
   assign rsp_point_y = point[1];
   assign rsp_point_z = point[2];

endmodule

@@ src/ied_checker.sv @@
// Port-level checks for the isosurface edge interpolator, bound to the top.
// Depends on isosurface_edge_interpolate_macros.svh.
`include "isosurface_edge_interpolate_macros.svh"

module ied_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_point_x,
   input logic        rsp_degenerate,
   input logic        rsp_saturated
);
   `IEI_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp dropped")
   `IEI_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_point_x), "rsp changed")
   `IEI_ASSERT(a_degen_nosat, clock, reset, rsp_valid && rsp_degenerate |-> !rsp_saturated, "degenerate and saturated")
   `IEI_ASSERT(a_ready_stall, clock, reset, req_ready |-> (!rsp_valid || rsp_ready), "accept while output stalled")
   `IEI_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "rsp after reset")

endmodule

bind isosurface_edge_interpolate ied_checker u_ied_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_point_x   (rsp_point_x),
   .rsp_degenerate(rsp_degenerate),
   .rsp_saturated (rsp_saturated)
);

@@ sim/testbench.sv @@
// Self-checking testbench for isosurface_edge_interpolate (marching cubes edge crossing).
// Depends on ied_pkg and the RTL of the interpolator; predicts every crossing point itself.
`timescale 1ns / 100ps

module testbench;

   localparam int FRAC       = ied_pkg::FRAC_BITS_DEF;
   localparam int DRAIN      = 45;       // pipe depth (37) plus margin
   localparam int CYCLE_CAP  = 400000;

   typedef struct packed {
      logic [2:0][31:0] a;
      logic [2:0][31:0] b;
      logic [31:0]      fa;
      logic [31:0]      fb;
   } edge_item_type;

   typedef struct packed {
      logic [2:0][31:0] p;
      logic             degen;
      logic             sat;
   } crossing_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic signed [31:0] csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_a_x = '0, req_a_y = '0, req_a_z = '0, req_field_a = '0;
   logic signed [31:0] req_b_x = '0, req_b_y = '0, req_b_z = '0, req_field_b = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_point_x, rsp_point_y, rsp_point_z;
   logic               rsp_degenerate, rsp_saturated;

   logic signed [31:0] iso_shadow = '0;      // our copy of the iso_value register
   crossing_type       crossing_q[$];        // expected crossings, oldest first
   int                 mismatch_count = 0;
   int                 cycle_count = 0;
   int                 stall_pct = 0;        // receiver stall odds in percent

   isosurface_edge_interpolate dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_a_x(req_a_x), .req_a_y(req_a_y), .req_a_z(req_a_z), .req_field_a(req_field_a),
      .req_b_x(req_b_x), .req_b_y(req_b_y), .req_b_z(req_b_z), .req_field_b(req_field_b),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_point_x(rsp_point_x), .rsp_point_y(rsp_point_y), .rsp_point_z(rsp_point_z),
      .rsp_degenerate(rsp_degenerate), .rsp_saturated(rsp_saturated)
   );

   always #2 clock = ~clock;

   // Watchdog: end the run if the pipe hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Receiver: always ready while cycle_count[7:6] is zero, random stalls otherwise.
   always @(negedge clock) begin
      if (cycle_count[7:6] == 2'd0)
         rsp_ready <= 1'b1;
      else
         rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic longint unsigned magnitude(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   // Crossing point of the isovalue along one edge, with saturation flags.
   function automatic crossing_type predict_crossing(edge_item_type e, logic signed [31:0] iso);
      crossing_type       r;
      longint             num, den, lam, d, s, sum;
      longint unsigned    q, m;
      bit                 neg;
      r.degen = 1'b0;
      r.sat   = 1'b0;
      num = longint'(iso) - longint'($signed(e.fa));
      den = longint'($signed(e.fb)) - longint'($signed(e.fa));
      if (den == 0) begin
         // equal field values: hand back endpoint a
         r.degen = 1'b1;
         r.p     = e.a;
         return r;
      end
      neg = (num < 0) != (den < 0);
      q   = (magnitude(num) << FRAC) / magnitude(den);
      if (neg) begin
         if (q > 64'h8000_0000) begin
            q = 64'h8000_0000;
            r.sat = 1'b1;
         end
         lam = -longint'(q);
      end else begin
         if (q > 64'h7FFF_FFFF) begin
            q = 64'h7FFF_FFFF;
            r.sat = 1'b1;
         end
         lam = longint'(q);
      end
      for (int i = 0; i < 3; i++) begin
         d   = longint'($signed(e.b[i])) - longint'($signed(e.a[i]));
         m   = (magnitude(d) * magnitude(lam)) >> FRAC;
         s   = ((d < 0) != (lam < 0)) ? -longint'(m) : longint'(m);
         sum = longint'($signed(e.a[i])) + s;
         if (sum > 64'sd2147483647) begin
            sum = 64'sd2147483647;
            r.sat = 1'b1;
         end else if (sum < -64'sd2147483648) begin
            sum = -64'sd2147483648;
            r.sat = 1'b1;
         end
         r.p[i] = sum[31:0];
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("[%0d] %s: got %h expected %h", cycle_count, what, got, want);
      mismatch_count++;
   endtask

   // Compare each accepted crossing with the oldest expectation.
   always @(posedge clock) begin
      crossing_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (crossing_q.size() == 0)
            report_mismatch("unexpected item", rsp_point_x, '0);
         else begin
            want = crossing_q.pop_front();
            if (rsp_point_x !== want.p[0]) report_mismatch("point_x", rsp_point_x, want.p[0]);
            if (rsp_point_y !== want.p[1]) report_mismatch("point_y", rsp_point_y, want.p[1]);
            if (rsp_point_z !== want.p[2]) report_mismatch("point_z", rsp_point_z, want.p[2]);
            if (rsp_degenerate !== want.degen)
               report_mismatch("degenerate", 32'(rsp_degenerate), 32'(want.degen));
            if (rsp_saturated !== want.sat)
               report_mismatch("saturated", 32'(rsp_saturated), 32'(want.sat));
         end
      end
   end

   // Present one edge at the falling edge and hold it until accepted; valid stays high.
   task automatic send_edge(edge_item_type e);
      @(negedge clock);
      req_valid   = 1'b1;
      req_a_x     = e.a[0];
      req_a_y     = e.a[1];
      req_a_z     = e.a[2];
      req_field_a = e.fa;
      req_b_x     = e.b[0];
      req_b_y     = e.b[1];
      req_b_z     = e.b[2];
      req_field_b = e.fb;
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      crossing_q.push_back(predict_crossing(e, iso_shadow));
   endtask

   // Drop valid for a number of cycles.
   task automatic hold_off(int n);
      @(negedge clock);
      req_valid = 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // Write iso_value with the pipe drained.
   task automatic write_iso(logic signed [31:0] v);
      hold_off(0);
      while (crossing_q.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
      csr_valid = 1'b1;
      csr_wdata = v;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      iso_shadow = v;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic edge_item_type make_edge(logic [31:0] ax, logic [31:0] ay,
                                               logic [31:0] az, logic [31:0] fa,
                                               logic [31:0] bx, logic [31:0] by,
                                               logic [31:0] bz, logic [31:0] fb);
      edge_item_type e;
      e.a  = {az, ay, ax};
      e.b  = {bz, by, bx};
      e.fa = fa;
      e.fb = fb;
      return e;
   endfunction

   // Edge whose field values bracket the isovalue: the common case in a volume scan.
   function automatic edge_item_type bracketing_edge();
      edge_item_type e;
      longint        lo, hi, base;
      for (int i = 0; i < 3; i++) begin
         base   = longint'($signed($urandom_range(32'h00FF_FFFF))) - 64'sd8388608;
         e.a[i] = base[31:0];
         e.b[i] = 32'(base + longint'($urandom_range(32'h0002_0000)) - 64'sd65536);
      end
      lo = longint'(iso_shadow) - longint'($urandom_range(32'h0004_0000));
      hi = longint'(iso_shadow) + longint'($urandom_range(32'h0004_0000));
      if (lo < -64'sd2147483648) lo = -64'sd2147483648;
      if (hi > 64'sd2147483647)  hi = 64'sd2147483647;
      if ($urandom_range(1)) begin
         e.fa = lo[31:0];
         e.fb = hi[31:0];
      end else begin
         e.fa = hi[31:0];
         e.fb = lo[31:0];
      end
      return e;
   endfunction

   function automatic edge_item_type noise_edge();
      edge_item_type e;
      e.a  = {$urandom, $urandom, $urandom};
      e.b  = {$urandom, $urandom, $urandom};
      e.fa = $urandom;
      e.fb = ($urandom_range(9) == 0) ? e.fa : $urandom;
      return e;
   endfunction

   // Extremes, degenerate edges, clipped lambda and clipped coordinates, back to back.
   task automatic test_directed();
      stall_pct = 0;
      send_edge(make_edge(0, 0, 0, 32'h0000_0000, 32'h0001_0000, 32'h0002_0000,
                          32'h0003_0000, 32'h0002_0000));           // lambda 0: point at a
      send_edge(make_edge(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 32'h0001_0000,
                          0, 0, 0, 32'h0001_0000));                 // equal fields
      send_edge(make_edge(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
                          0, 0, 0, 32'h8000_0000));                 // equal at the low bound
      send_edge(make_edge(1, 2, 3, 32'h8000_0000, 4, 5, 6, 32'h8000_0001)); // lambda clipped
      send_edge(make_edge(1, 2, 3, 32'h7FFF_FFFF, 4, 5, 6, 32'h7FFF_FFFE)); // lambda clipped, both diffs < 0
      send_edge(make_edge(32'h7FFF_0000, 32'h8001_0000, 0, 32'h0001_0000,
                          32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000,
                          32'h0002_0000));                          // lambda -1: coords clip
      send_edge(make_edge(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF));                          // widest span
      send_edge(make_edge(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
      send_edge(make_edge(0, 0, 0, 32'h0003_0000, 32'h0001_0000, 32'hFFFF_0000,
                          32'h0000_8000, 32'hFFFF_0000));           // falling field
      send_edge(make_edge(32'h0000_0001, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 0, 1, 1));                 // one-lsb values
      write_iso(32'sh7FFF_FFFF);
      send_edge(make_edge(0, 0, 0, 32'h8000_0000, 32'h0001_0000, 1, 2,
                          32'h7FFF_FFFF));                          // lambda exactly 1: point at b
      send_edge(make_edge(5, 6, 7, 32'h7FFF_FFFF, 8, 9, 10, 32'h7FFF_FFFF));
      send_edge(make_edge(5, 6, 7, 0, 8, 9, 10, 1));
      write_iso(32'sh8000_0000);
      send_edge(make_edge(5, 6, 7, 32'h7FFF_FFFF, 8, 9, 10, 32'h8000_0000));
      send_edge(make_edge(5, 6, 7, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 10, 0));
      send_edge(make_edge(5, 6, 7, 1, 8, 9, 10, 0));
   endtask

   // Random edges in bursts with gaps, receiver stalls at the given odds.
   task automatic test_random(int count, int stall_odds, int noise_pct);
      int burst;
      stall_pct = stall_odds;
      while (count > 0) begin
         burst = $urandom_range(12, 1);
         for (int i = 0; i < burst && count > 0; i++, count--)
            send_edge(($urandom_range(99) < noise_pct) ? noise_edge() : bracketing_edge());
         if ($urandom_range(3) != 0) hold_off($urandom_range(5, 1));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random(80, 0, 20);
      write_iso(32'sh0001_8000);
      test_random(80, 30, 20);
      write_iso(32'sh7FFF_FFFF);
      test_random(60, 60, 30);
      write_iso(32'sh8000_0000);
      test_random(60, 10, 30);
      write_iso($urandom);
      test_random(120, 40, 25);

      hold_off(0);
      while (crossing_q.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
      if (crossing_q.size() != 0)
         report_mismatch("items left over", 32'(crossing_q.size()), '0);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
